[sv/scfr_pkg.sv]
// Shared types and constants for the sum-checked frame receiver.
// Depends on nothing; imported by every module of the block.
package scfr_pkg;

   localparam int unsigned BYTE_W        = 8;
   localparam int unsigned LEN_OUT_W     = 5;
   localparam int unsigned PAYLOAD_KEEP  = 4;
   localparam int unsigned PAY_IDX_W     = $clog2(PAYLOAD_KEEP);
   localparam int unsigned QUEUE_DEPTH   = 2;
   localparam int unsigned QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W   = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0] START_MARKER_RESET = 8'd170;

   typedef logic [BYTE_W-1:0] byte_type;
   typedef logic [PAYLOAD_KEEP-1:0][BYTE_W-1:0] payload_type;

   typedef struct packed {
      logic                 checksum_ok;
      byte_type             frame_type;
      logic [LEN_OUT_W-1:0] payload_length;
      payload_type          payload;
   } frame_result_type;

   typedef struct packed {
      logic not_empty;
      logic full;
   } queue_status_type;

endpackage

[sv/scfr_front.sv]
// Front end: start-marker hunt, frame parsing and running checksum.
// Pushes one frame record per complete frame; oversize frames are dropped. Uses scfr_pkg.
module scfr_front #(
   parameter int unsigned MAX_FRAME = 32
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      take,
   input  scfr_pkg::byte_type        rx_byte,
   input  logic                      marker_wr_en,
   input  scfr_pkg::byte_type        marker_wr_data,
   output logic                      push,
   output scfr_pkg::frame_result_type push_data
);
   import scfr_pkg::*;

   localparam int unsigned PW  = $clog2(MAX_FRAME);
   localparam int unsigned EW  = BYTE_W + 1;
   localparam logic [PW-1:0] POS_HUNT  = PW'(0);
   localparam logic [PW-1:0] POS_TYPE  = PW'(1);
   localparam logic [PW-1:0] POS_LEN   = PW'(2);
   localparam logic [PW-1:0] POS_FIRST = PW'(3);
   localparam logic [PW:0]   MAX_V     = (PW+1)'(MAX_FRAME);

   byte_type        marker_ff, marker_in;
   logic [PW-1:0]   pos_ff, pos_in;
   byte_type        type_ff, type_in;
   byte_type        len_ff, len_in;
   byte_type        sum_ff, sum_in;
   payload_type     pay_ff, pay_in;

   logic [EW-1:0]   end_pos;
   logic [EW-1:0]   pos_ext;
   logic [PW:0]     pos_inc;
   logic [PW-1:0]   pay_k;

   assign end_pos = EW'(len_ff) + EW'(POS_FIRST);
   assign pos_ext = EW'(pos_ff);
   assign pos_inc = (PW+1)'(pos_ff) + (PW+1)'(1);
   assign pay_k   = pos_ff - POS_FIRST;

   assign marker_in = marker_wr_en ? marker_wr_data : marker_ff;

   always_comb begin
      pos_in  = pos_ff;
      type_in = type_ff;
      len_in  = len_ff;
      sum_in  = sum_ff;
      pay_in  = pay_ff;
      push    = 1'b0;
      if (take) begin
         if (pos_ff == POS_HUNT) begin
            if (rx_byte == marker_ff) begin
               sum_in = '0;
               pay_in = '0;
               pos_in = POS_TYPE;
            end
         end else if (pos_ff == POS_TYPE) begin
            type_in = rx_byte;
            sum_in  = sum_ff + rx_byte;
            pos_in  = POS_LEN;
         end else if (pos_ff == POS_LEN) begin
            len_in = rx_byte;
            sum_in = sum_ff + rx_byte;
            pos_in = POS_FIRST;
         end else if (pos_ext < end_pos) begin
            if (pay_k < PW'(PAYLOAD_KEEP)) begin
               pay_in[pay_k[PAY_IDX_W-1:0]] = rx_byte;
            end
            sum_in = sum_ff + rx_byte;
            // A frame that reaches the size limit without ending is dropped.
            if (pos_inc >= MAX_V) begin
               pos_in = POS_HUNT;
            end else begin
               pos_in = pos_inc[PW-1:0];
            end
         end else begin
            push   = 1'b1;
            pos_in = POS_HUNT;
         end
      end
   end

   always_comb begin
      push_data.checksum_ok    = (rx_byte == sum_ff);
      push_data.frame_type     = type_ff;
      push_data.payload_length = len_ff[LEN_OUT_W-1:0];
      push_data.payload        = pay_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marker_ff <= START_MARKER_RESET;
         pos_ff    <= POS_HUNT;
      end else begin
         marker_ff <= marker_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      type_ff <= type_in;
      len_ff  <= len_in;
      sum_ff  <= sum_in;
      pay_ff  <= pay_in;
   end

endmodule

[sv/scfr_queue.sv]
// Short FIFO of completed frame records between front and back end.
// Uses scfr_pkg for the record type and depth.
module scfr_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  scfr_pkg::frame_result_type push_data,
   input  logic                       pop,
   output scfr_pkg::frame_result_type pop_data,
   output scfr_pkg::queue_status_type status
);
   import scfr_pkg::*;

   frame_result_type             entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]       count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QUEUE_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QUEUE_PTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + QUEUE_CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - QUEUE_CNT_W'(1);
      end
   end

   assign status.not_empty = (count_ff != '0);
   assign status.full      = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign pop_data         = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[sv/scfr_back.sv]
// Back end: output register that presents frame records on the response channel.
// Uses scfr_pkg for the record and queue status types.
module scfr_back (
   input  logic                       clock,
   input  logic                       reset,
   input  scfr_pkg::queue_status_type q_status,
   input  scfr_pkg::frame_result_type q_data,
   output logic                       pop,
   input  logic                       out_ready,
   output logic                       out_valid,
   output scfr_pkg::frame_result_type out_data
);
   import scfr_pkg::*;

   logic             valid_ff, valid_in;
   frame_result_type data_ff, data_in;

   // Refill the output register whenever it is empty or being drained.
   assign pop = q_status.not_empty && (!valid_ff || out_ready);

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (pop) begin
         valid_in = 1'b1;
         data_in  = q_data;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

endmodule

[sv/sum_checked_frame_receiver_core.sv]
// Sum-checked frame receiver: top level joining front end, queue and back end.
// Depends on scfr_pkg, scfr_front, scfr_queue and scfr_back.
//
// Usage:
//   Each request carries one received byte on req_rx_byte. Frames have the form
//   start marker, type, length L, L payload bytes, checksum. One response is
//   given per complete frame with the checksum flag, type, length and the first
//   four payload bytes (zero where the frame has fewer).
//   Frames whose total size would exceed MAX_FRAME bytes are dropped silently.
//   The start marker is written through csr_wr_en / csr_wr_data while idle.
// Timing:
//   One request is accepted every cycle while the queue is not full. rsp_valid
//   for a frame rises once the back end has loaded it: the front end pushes
//   into a two-entry queue at the edge that accepts its checksum byte, and the
//   back end loads its output register from it when free or draining.
// Reset:
//   Synchronous reset returns the parser to hunting, empties the queue, drops
//   any pending response and restores the start marker to 170.
// Stalls:
//   When rsp_ready is low the output register holds; the queue absorbs further
//   frames and req_ready falls only once the queue is full.
module sum_checked_frame_receiver_core #(
   parameter int unsigned MAX_FRAME = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [scfr_pkg::BYTE_W-1:0]       req_rx_byte,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic                              rsp_checksum_ok,
   output logic [scfr_pkg::BYTE_W-1:0]       rsp_frame_type,
   output logic [scfr_pkg::LEN_OUT_W-1:0]    rsp_payload_length,
   output logic [scfr_pkg::BYTE_W-1:0]       rsp_payload_byte0,
   output logic [scfr_pkg::BYTE_W-1:0]       rsp_payload_byte1,
   output logic [scfr_pkg::BYTE_W-1:0]       rsp_payload_byte2,
   output logic [scfr_pkg::BYTE_W-1:0]       rsp_payload_byte3,
   input  logic                              csr_wr_en,
   input  logic [scfr_pkg::BYTE_W-1:0]       csr_wr_data
);
   import scfr_pkg::*;

   logic             take;
   logic             push;
   logic             pop;
   frame_result_type push_data;
   frame_result_type q_data;
   frame_result_type out_data;
   queue_status_type q_status;

   assign req_ready = !q_status.full;
   assign take      = req_valid && req_ready;

   scfr_front #(
      .MAX_FRAME (MAX_FRAME)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .rx_byte        (req_rx_byte),
      .marker_wr_en   (csr_wr_en),
      .marker_wr_data (csr_wr_data),
      .push           (push),
      .push_data      (push_data)
   );

   scfr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (q_data),
      .status    (q_status)
   );

   scfr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_status  (q_status),
      .q_data    (q_data),
      .pop       (pop),
      .out_ready (rsp_ready),
      .out_valid (rsp_valid),
      .out_data  (out_data)
   );

   assign rsp_checksum_ok    = out_data.checksum_ok;
   assign rsp_frame_type     = out_data.frame_type;
   assign rsp_payload_length = out_data.payload_length;
   assign rsp_payload_byte0  = out_data.payload[0];
   assign rsp_payload_byte1  = out_data.payload[1];
   assign rsp_payload_byte2  = out_data.payload[2];
   assign rsp_payload_byte3  = out_data.payload[3];

`ifndef SYNTHESIS
   // A frame record must never be pushed into a full queue.
   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full)
      else $error("frame record pushed into full queue");

   // The back end only loads while its output register is free or draining.
   a_pop_only_when_free: assert property (@(posedge clock) disable iff (reset)
      pop |-> (!rsp_valid || rsp_ready))
      else $error("output register overwritten while stalled");

   // No response is pending right after reset.
   a_reset_clears_rsp: assert property (@(posedge clock)
      $fell(reset) |-> !rsp_valid)
      else $error("response valid right after reset");
`endif

endmodule
